// File: rtl/nfha_pkg.sv
// Package for the next-fit heap allocator: store geometry, header word,
// memory request, result word and status codes. No dependencies.
`timescale 1ns / 1ps

package nfha_pkg;

  localparam int MEM_BYTES    = 65536;
  localparam int HEADER_BYTES = 16;
  localparam int STORE_WORDS  = MEM_BYTES / 4;
  localparam int WIDX_W       = $clog2(STORE_WORDS);   // header word index
  localparam int OFF_W        = WIDX_W + 3;            // byte offset incl. store end
  localparam int SIZE_W       = WIDX_W + 2;            // chunk size in bytes
  localparam int REQ_W        = 17;
  localparam int RND_W        = REQ_W + 1;             // rounded request
  localparam int USED_W       = 17;
  localparam int CNT_W        = 13;
  localparam int STAT_W       = 3;

  localparam logic [OFF_W-1:0]  MEM_END  = OFF_W'(MEM_BYTES);
  localparam logic [OFF_W-1:0]  WRAP_AT  = OFF_W'(MEM_BYTES - HEADER_BYTES);
  localparam logic [OFF_W-1:0]  HDR_OFF  = OFF_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] HDR_SIZE = SIZE_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] FIRST_SIZE = SIZE_W'(MEM_BYTES - HEADER_BYTES);

  localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO     = 3'd1;
  localparam logic [STAT_W-1:0] STAT_NO_MEM   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_HEAD = 3'd3;
  localparam logic [STAT_W-1:0] STAT_IS_FREE  = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;

  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  typedef struct packed {
    logic [WIDX_W-1:0] raddr;
    logic              we;
    logic [WIDX_W-1:0] waddr;
    hdr_t              wdata;
  } mem_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [15:0]       payload_offset;
    logic [USED_W-1:0] bytes_in_use;
    logic [CNT_W-1:0]  chunks_in_chain;
    logic [USED_W-1:0] peak_bytes_in_use;
  } res_t;

  typedef struct packed {
    logic [OFF_W-1:0] nxt;
    logic             wrapped;
    logic             stop;
  } walk_t;

  // One hop of the next-fit walk, wrapping once at the end of the store.
  function automatic walk_t walk_step(input logic [OFF_W-1:0] act,
                                      input logic [SIZE_W-1:0] size,
                                      input logic wrapped,
                                      input logic [OFF_W-1:0] start);
    walk_t w;
    w.nxt     = act + OFF_W'(size) + HDR_OFF;
    w.wrapped = wrapped;
    if (w.nxt >= WRAP_AT) begin
      w.nxt     = '0;
      w.wrapped = 1'b1;
    end
    w.stop = w.wrapped && (w.nxt >= start);
    return w;
  endfunction

  function automatic logic [WIDX_W-1:0] word_idx(input logic [OFF_W-1:0] off);
    return off[WIDX_W+1:2];
  endfunction

endpackage

// File: rtl/nfha_store.sv
// Header store: one synchronous RAM, one write and one registered read
// per cycle. Depends on nfha_pkg.
`timescale 1ns / 1ps

module nfha_store
  import nfha_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output hdr_t     rdata
);

  hdr_t mem [STORE_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

// File: rtl/nfha_ctrl.sv
// Allocator sequencer: chain walks, split/absorb, free with coalescing,
// counters. Drives the header store. Depends on nfha_pkg.
`timescale 1ns / 1ps

module nfha_ctrl
  import nfha_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_go,
  input  logic               kind,
  input  logic [REQ_W-1:0]   request_bytes,
  input  logic [15:0]        payload_offset_in,
  output logic               idle,
  output logic               res_valid,
  input  logic               res_ack,
  output res_t               res,
  output mem_req_t           mreq,
  input  hdr_t               rdata
);

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_AWALK  = 3'd2;
  localparam logic [2:0] S_ANEW   = 3'd3;
  localparam logic [2:0] S_FWALK  = 3'd4;
  localparam logic [2:0] S_FMERGE = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state, state_next;
  logic [OFF_W-1:0]  act, act_next;
  logic [OFF_W-1:0]  start, start_next;
  logic              wrapped, wrapped_next;
  logic              second, second_next;
  logic [RND_W-1:0]  rnd, rnd_next;
  logic [RND_W-1:0]  min_sz, min_sz_next;
  logic [OFF_W-1:0]  f, f_next;
  logic [SIZE_W-1:0] fsz, fsz_next;
  logic [15:0]       target, target_next;
  logic [OFF_W-1:0]  prev, prev_next;
  hdr_t              prev_word, prev_word_next;
  logic              has_prev, has_prev_next;
  logic              next_ok, next_ok_next;
  logic              upd_peak, upd_peak_next;
  logic [WIDX_W-1:0] sp, sp_next;
  logic [USED_W-1:0] used, used_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [USED_W-1:0] peak;
  logic [STAT_W-1:0] status, status_next;
  logic [15:0]       pay, pay_next;

  walk_t             step, step2;
  logic              hit;
  logic [SIZE_W-1:0] left;
  logic [OFF_W-1:0]  after;
  logic              mn, mp;
  logic [SIZE_W-1:0] sz2;
  logic [USED_W-1:0] peak_out;

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign peak_out  = (upd_peak && used > peak) ? used : peak;
  assign res       = '{status: status, payload_offset: pay, bytes_in_use: used,
                       chunks_in_chain: count, peak_bytes_in_use: peak_out};

  always_comb begin
    state_next     = state;
    act_next       = act;
    start_next     = start;
    wrapped_next   = wrapped;
    second_next    = second;
    rnd_next       = rnd;
    min_sz_next    = min_sz;
    f_next         = f;
    fsz_next       = fsz;
    target_next    = target;
    prev_next      = prev;
    prev_word_next = prev_word;
    has_prev_next  = has_prev;
    next_ok_next   = next_ok;
    upd_peak_next  = upd_peak;
    sp_next        = sp;
    used_next      = used;
    count_next     = count;
    status_next    = status;
    pay_next       = pay;
    mreq           = '0;

    hit   = rdata.free && (RND_W'(rdata.size) >= min_sz);
    step  = walk_step(act, rdata.size, wrapped, start);
    step2 = walk_step(act, rdata.size, 1'b0, act);
    left  = rdata.size - rnd[SIZE_W-1:0];
    after = act + HDR_OFF + OFF_W'(rdata.size);
    mn    = next_ok && rdata.free;
    mp    = has_prev && prev_word.free;
    sz2   = fsz + (mn ? (rdata.size + HDR_SIZE) : '0);

    unique case (state)
      S_INIT: begin
        mreq.we    = 1'b1;
        mreq.waddr = '0;
        mreq.wdata = '{free: 1'b1, size: FIRST_SIZE};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_go) begin
          pay_next      = '0;
          upd_peak_next = 1'b0;
          if (kind == KIND_ALLOC) begin
            if (request_bytes == '0) begin
              status_next = STAT_ZERO;
              state_next  = S_DONE;
            end else begin
              rnd_next      = (RND_W'(request_bytes) + RND_W'(3)) & ~RND_W'(3);
              min_sz_next   = (RND_W'(request_bytes) + RND_W'(3)) & ~RND_W'(3);
              second_next   = 1'b0;
              start_next    = {1'b0, sp, 2'b00};
              act_next      = {1'b0, sp, 2'b00};
              wrapped_next  = 1'b0;
              upd_peak_next = 1'b1;
              mreq.raddr    = sp;
              state_next    = S_AWALK;
            end
          end else begin
            target_next   = payload_offset_in;
            act_next      = '0;
            has_prev_next = 1'b0;
            mreq.raddr    = '0;
            state_next    = S_FWALK;
          end
        end
      end
      S_AWALK: begin
        if (hit && !second) begin
          f_next    = act;
          fsz_next  = rdata.size;
          pay_next  = 16'(act + HDR_OFF);
          mreq.we    = 1'b1;
          mreq.waddr = word_idx(act);
          if (left > HDR_SIZE) begin
            mreq.wdata = '{free: 1'b0, size: rnd[SIZE_W-1:0]};
            state_next = S_ANEW;
          end else begin
            // absorb: look for the next free chunk past this one
            mreq.wdata  = '{free: 1'b0, size: rdata.size};
            used_next   = used + USED_W'(rdata.size);
            status_next = STAT_OK;
            second_next = 1'b1;
            min_sz_next = '0;
            start_next  = act;
            if (step2.stop) begin
              sp_next    = word_idx(act);
              state_next = S_DONE;
            end else begin
              act_next     = step2.nxt;
              wrapped_next = step2.wrapped;
              mreq.raddr   = word_idx(step2.nxt);
            end
          end
        end else if (hit) begin
          sp_next    = word_idx(act);
          state_next = S_DONE;
        end else if (step.stop) begin
          if (!second) begin
            status_next = STAT_NO_MEM;
          end else begin
            sp_next = word_idx(f);
          end
          state_next = S_DONE;
        end else begin
          act_next     = step.nxt;
          wrapped_next = step.wrapped;
          mreq.raddr   = word_idx(step.nxt);
        end
      end
      S_ANEW: begin
        mreq.we     = 1'b1;
        mreq.waddr  = word_idx(f + HDR_OFF + OFF_W'(rnd));
        mreq.wdata  = '{free: 1'b1, size: fsz - rnd[SIZE_W-1:0] - HDR_SIZE};
        sp_next     = word_idx(f + HDR_OFF + OFF_W'(rnd));
        used_next   = used + USED_W'(rnd) + USED_W'(HEADER_BYTES);
        count_next  = count + CNT_W'(1);
        status_next = STAT_OK;
        state_next  = S_DONE;
      end
      S_FWALK: begin
        if (act + HDR_OFF == {1'b0, target}) begin
          f_next = act;
          if (rdata.free) begin
            status_next = STAT_IS_FREE;
            state_next  = S_DONE;
          end else begin
            fsz_next     = rdata.size;
            next_ok_next = (after < MEM_END);
            mreq.raddr   = word_idx(after);
            state_next   = S_FMERGE;
          end
        end else begin
          prev_next      = act;
          prev_word_next = rdata;
          has_prev_next  = 1'b1;
          if (after >= MEM_END) begin
            status_next = STAT_NOT_HEAD;
            state_next  = S_DONE;
          end else begin
            act_next   = after;
            mreq.raddr = word_idx(after);
          end
        end
      end
      S_FMERGE: begin
        // f holds the freed header, fsz its size, rdata the next header
        mreq.we = 1'b1;
        if (mp) begin
          mreq.waddr = word_idx(prev);
          mreq.wdata = '{free: 1'b1, size: prev_word.size + sz2 + HDR_SIZE};
        end else begin
          mreq.waddr = word_idx(f);
          mreq.wdata = '{free: 1'b1, size: sz2};
        end
        if (mn && sp == word_idx(f + HDR_OFF + OFF_W'(fsz))) begin
          sp_next = mp ? word_idx(prev) : word_idx(f);
        end else if (mp && sp == word_idx(f)) begin
          sp_next = word_idx(prev);
        end
        used_next   = used - USED_W'(fsz) - (mn ? USED_W'(HEADER_BYTES) : '0)
                           - (mp ? USED_W'(HEADER_BYTES) : '0);
        count_next  = count - CNT_W'(mn) - CNT_W'(mp);
        status_next = STAT_OK;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (res_ack) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      sp       <= '0;
      used     <= USED_W'(HEADER_BYTES);
      count    <= CNT_W'(1);
      peak     <= '0;
      upd_peak <= 1'b0;
    end else begin
      state    <= state_next;
      sp       <= sp_next;
      used     <= used_next;
      count    <= count_next;
      upd_peak <= upd_peak_next;
      if (state == S_DONE && res_ack) begin
        peak <= peak_out;
      end
    end
    act       <= act_next;
    start     <= start_next;
    wrapped   <= wrapped_next;
    second    <= second_next;
    rnd       <= rnd_next;
    min_sz    <= min_sz_next;
    f         <= f_next;
    fsz       <= fsz_next;
    target    <= target_next;
    prev      <= prev_next;
    prev_word <= prev_word_next;
    has_prev  <= has_prev_next;
    next_ok   <= next_ok_next;
    status    <= status_next;
    pay       <= pay_next;
  end

`ifndef SYNTHESIS
  a_chain_nonempty: assert property (@(posedge clk) disable iff (rst) count != '0)
    else $error("chunk count reached zero");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_DONE) |-> !mreq.we)
    else $error("header write outside a request");
  a_split_adds: assert property (@(posedge clk) disable iff (rst)
    (state == S_ANEW) |=> count == $past(count) + CNT_W'(1))
    else $error("split did not add a chunk");
  a_free_shrinks: assert property (@(posedge clk) disable iff (rst)
    (state == S_FMERGE) |=> count <= $past(count) && used < $past(used))
    else $error("free did not release bytes");
`endif

endmodule

// File: rtl/next_fit_heap_allocator_unit.sv
// Top level of the next-fit heap allocator: input handshake, result
// register, sequencer and header store. Depends on nfha_pkg, nfha_ctrl, nfha_store.
`timescale 1ns / 1ps
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+----------------------------------
//  in      | into      | in_valid/in_stall   | kind, request_bytes, payload_offset_in
//  out     | out of    | out_valid/out_stall | status, payload_offset, bytes_in_use,
//          |           |                     | chunks_in_chain, peak_bytes_in_use
//
//  One request at a time. An allocate walks the chunk headers in S_AWALK
//  (up to two passes round the chain), then writes the split remainder in S_ANEW.
//  A free walks the chain from the start of the store in S_FWALK, then S_FMERGE
//  writes the merged header; a rejected free ends after the walk.
//  The rate is set by the header RAM: one header read per cycle.
//  After reset the S_INIT state writes the initial free chunk; in_stall is high then.
//  A finished result sits in the output register; the next request is taken
//  while it waits, and a new result waits in the sequencer until out is free.

module next_fit_heap_allocator_unit
  import nfha_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [REQ_W-1:0]   request_bytes,
  input  logic [15:0]        payload_offset_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  status,
  output logic [15:0]        payload_offset,
  output logic [USED_W-1:0]  bytes_in_use,
  output logic [CNT_W-1:0]   chunks_in_chain,
  output logic [USED_W-1:0]  peak_bytes_in_use
);

  logic     idle;
  logic     res_valid;
  logic     res_ack;
  res_t     res;
  mem_req_t mreq;
  hdr_t     rdata;

  assign in_stall = !idle;
  // the result register loads a finished result whenever it is empty or being drained
  assign res_ack  = res_valid && (!out_valid || !out_stall);

  nfha_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_go            (in_valid && idle),
    .kind             (kind),
    .request_bytes    (request_bytes),
    .payload_offset_in(payload_offset_in),
    .idle             (idle),
    .res_valid        (res_valid),
    .res_ack          (res_ack),
    .res              (res),
    .mreq             (mreq),
    .rdata            (rdata)
  );

  nfha_store u_store (
    .clk  (clk),
    .req  (mreq),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ack) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_ack) begin
      status            <= res.status;
      payload_offset    <= res.payload_offset;
      bytes_in_use      <= res.bytes_in_use;
      chunks_in_chain   <= res.chunks_in_chain;
      peak_bytes_in_use <= res.peak_bytes_in_use;
    end
  end

endmodule

// File: verif/tb_top.sv
// Self-checking bench for next_fit_heap_allocator_unit: a behavioral heap
// model predicts each result word. Depends on nfha_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_top;
  import nfha_pkg::*;

  // Stimulus word and expected result word.
  typedef struct packed {
    logic              kind;
    logic [REQ_W-1:0]  req;
    logic [15:0]       off;
  } heap_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [15:0]       pay;
    logic [USED_W-1:0] used;
    logic [CNT_W-1:0]  chunks;
    logic [USED_W-1:0] peak;
  } heap_res_t;

  localparam int MAX_CYCLES = 20000000;
  localparam int WALK_MAX   = STORE_WORDS + 4;
  localparam logic [31:0] FREE_MARK = 32'h8000_0000;
  localparam logic [31:0] SIZE_MASK = 32'h0FFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic kind = 1'b0;
  logic [REQ_W-1:0] request_bytes = '0;
  logic [15:0] payload_offset_in = '0;
  logic out_stall = 1'b0;
  logic in_stall, out_valid;
  logic [STAT_W-1:0] status;
  logic [15:0] payload_offset;
  logic [USED_W-1:0] bytes_in_use, peak_bytes_in_use;
  logic [CNT_W-1:0] chunks_in_chain;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  next_fit_heap_allocator_unit dut (.*);

  // ---------------- heap model ----------------
  logic [31:0] heap_words [STORE_WORDS];
  int unsigned rover, used_bytes, chunk_total, peak_bytes;
  int unsigned live_pay[$];       // payload offsets currently allocated
  heap_req_t   pending_reqs[$];
  heap_res_t   expected_results[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;      // no idling in the final stretch

  function automatic logic [31:0] hrd(int unsigned off, int unsigned w);
    int unsigned i;
    i = (off >> 2) + w;
    return i < STORE_WORDS ? heap_words[i] : 32'd0;
  endfunction

  function automatic void hwr(int unsigned off, int unsigned w, logic [31:0] v);
    int unsigned i;
    i = (off >> 2) + w;
    if (i < STORE_WORDS) heap_words[i] = v;
  endfunction

  function automatic int unsigned csz(int unsigned off);
    return hrd(off, 0) & SIZE_MASK;
  endfunction

  function automatic bit cfr(int unsigned off);
    return (hrd(off, 0) & FREE_MARK) != 32'd0;
  endfunction

  // Next-fit walk from start, wrapping once.
  function automatic bit seek_free(int unsigned start, int unsigned need,
                                   output int unsigned got);
    int unsigned act;
    bit wrapped;
    act = start;
    wrapped = 1'b0;
    got = 0;
    for (int g = 0; g < WALK_MAX; g++) begin
      if (cfr(act) && csz(act) >= need) begin
        got = act;
        return 1'b1;
      end
      act += csz(act) + HEADER_BYTES;
      if (act >= MEM_BYTES - HEADER_BYTES) begin
        act = 0;
        wrapped = 1'b1;
      end
      if (wrapped && act >= start) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic logic [STAT_W-1:0] heap_alloc(int unsigned req,
                                                   output int unsigned pay);
    int unsigned r, f, sz, left, n, nn, nxt;
    pay = 0;
    if (req == 0) return STAT_ZERO;
    r = (req + 3) & ~32'd3;
    if (!seek_free(rover << 2, r, f)) begin
      if (used_bytes > peak_bytes) peak_bytes = used_bytes;
      return STAT_NO_MEM;
    end
    sz = csz(f);
    left = sz - r;
    if (left > HEADER_BYTES) begin
      hwr(f, 0, r);
      n = f + HEADER_BYTES + r;
      hwr(n, 0, ((left - HEADER_BYTES) & SIZE_MASK) | FREE_MARK);
      hwr(n, 1, f);
      nn = n + left;
      if (nn < MEM_BYTES) hwr(nn, 1, n);
      used_bytes += r + HEADER_BYTES;
      chunk_total++;
      rover = n >> 2;
    end else begin
      hwr(f, 0, sz);
      used_bytes += sz;
      // absorbed: park on the next free chunk, or stay here if none
      if (seek_free(f, 0, nxt)) rover = nxt >> 2;
      else rover = f >> 2;
    end
    if (used_bytes > peak_bytes) peak_bytes = used_bytes;
    pay = f + HEADER_BYTES;
    return STAT_OK;
  endfunction

  function automatic logic [STAT_W-1:0] heap_free(int unsigned target);
    int unsigned act, prv, h, sz, nx, nsz, after;
    bit has_prev, found;
    act = 0; prv = 0; has_prev = 0; found = 0;
    for (int g = 0; g < WALK_MAX && act < MEM_BYTES; g++) begin
      if (act + HEADER_BYTES == target) begin
        found = 1'b1;
        break;
      end
      prv = act;
      has_prev = 1'b1;
      act += csz(act) + HEADER_BYTES;
    end
    if (!found) return STAT_NOT_HEAD;
    h = act;
    if (cfr(h)) return STAT_IS_FREE;
    sz = csz(h);
    hwr(h, 0, sz | FREE_MARK);
    used_bytes -= sz;
    after = h + HEADER_BYTES + sz;
    nx = after;
    if (nx < MEM_BYTES && cfr(nx)) begin
      nsz = csz(nx);
      sz = sz + nsz + HEADER_BYTES;
      hwr(h, 0, (sz & SIZE_MASK) | FREE_MARK);
      if ((rover << 2) == nx) rover = h >> 2;
      hwr(nx, 0, 0);
      hwr(nx, 1, 0);
      after = nx + nsz + HEADER_BYTES;
      if (after < MEM_BYTES) hwr(after, 1, h);
      used_bytes -= HEADER_BYTES;
      chunk_total--;
    end
    if (has_prev && cfr(prv)) begin
      hwr(prv, 0, ((csz(prv) + sz + HEADER_BYTES) & SIZE_MASK) | FREE_MARK);
      if ((rover << 2) == h) rover = prv >> 2;
      hwr(h, 0, 0);
      hwr(h, 1, 0);
      if (after < MEM_BYTES) hwr(after, 1, prv);
      used_bytes -= HEADER_BYTES;
      chunk_total--;
    end
    return STAT_OK;
  endfunction

  function automatic void heap_clear();
    foreach (heap_words[i]) heap_words[i] = '0;
    hwr(0, 0, ((MEM_BYTES - HEADER_BYTES) & SIZE_MASK) | FREE_MARK);
    rover = 0;
    used_bytes = HEADER_BYTES;
    chunk_total = 1;
    peak_bytes = 0;
  endfunction

  // Predict one accepted request; also tracks live payloads for stimulus.
  function automatic void predict_heap(heap_req_t rq);
    heap_res_t e;
    int unsigned pay;
    pay = 0;
    if (rq.kind == KIND_ALLOC) begin
      e.status = heap_alloc(rq.req, pay);
      if (e.status == STAT_OK) live_pay.push_back(pay);
    end else begin
      e.status = heap_free(rq.off);
      if (e.status == STAT_OK)
        foreach (live_pay[i]) if (live_pay[i] == rq.off) begin
          live_pay.delete(i);
          break;
        end
    end
    e.pay    = pay[15:0];
    e.used   = used_bytes[USED_W-1:0];
    e.chunks = chunk_total[CNT_W-1:0];
    e.peak   = peak_bytes[USED_W-1:0];
    expected_results.push_back(e);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR @%0t %s: got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // ---------------- driver ----------------
  // Prediction is done at acceptance, so live_pay mirrors the DUT in order.
  // Free targets are picked from live_pay when the word is loaded.
  int unsigned in_gap = 0;
  int unsigned out_gap = 0;
  bit          in_taken = 1'b0;   // word on the input was accepted
  heap_req_t cur;

  function automatic heap_req_t resolve(heap_req_t rq);
    // req field 0x1FFFF with kind free is a marker: pick a live payload
    if (rq.kind != KIND_ALLOC && rq.req == '1 && live_pay.size() > 0)
      rq.off = live_pay[$urandom_range(0, live_pay.size() - 1)];
    return rq;
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_heap(cur);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_taken) begin
        // word taken at the last rising edge
        in_taken = 1'b0;
        if (in_gap == 0 && pending_reqs.size() > 0 && (quiet || $urandom_range(0, 7) != 0)) begin
          cur = resolve(pending_reqs.pop_front());
          kind <= cur.kind; request_bytes <= cur.req; payload_offset_in <= cur.off;
        end else begin
          in_valid <= 1'b0;
          if (!quiet && in_gap == 0) in_gap = $urandom_range(1, 17);
        end
      end else if (!in_valid) begin
        if (in_gap > 0) in_gap--;
        else if (pending_reqs.size() > 0) begin
          cur = resolve(pending_reqs.pop_front());
          kind <= cur.kind; request_bytes <= cur.req; payload_offset_in <= cur.off;
          in_valid <= 1'b1;
        end
      end
      // output stall in random bursts
      if (quiet) begin
        out_stall <= 1'b0;
        out_gap = 0;
      end else if (out_gap > 0) begin
        out_gap--;
        if (out_gap == 0) out_stall <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        out_stall <= 1'b1;
        out_gap = $urandom_range(1, 17);
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    heap_res_t e;
    cycle_count++;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("ERROR @%0t result word with nothing expected", $time);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (status !== e.status) report_mismatch("status", status, e.status);
        if (payload_offset !== e.pay) report_mismatch("payload_offset", payload_offset, e.pay);
        if (bytes_in_use !== e.used) report_mismatch("bytes_in_use", bytes_in_use, e.used);
        if (chunks_in_chain !== e.chunks)
          report_mismatch("chunks_in_chain", chunks_in_chain, e.chunks);
        if (peak_bytes_in_use !== e.peak)
          report_mismatch("peak_bytes_in_use", peak_bytes_in_use, e.peak);
      end
    end
    if (cycle_count > MAX_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic heap_req_t mk(logic k, int unsigned rq, int unsigned off);
    heap_req_t w;
    w.kind = k; w.req = rq[REQ_W-1:0]; w.off = off[15:0];
    return w;
  endfunction

  function automatic heap_req_t free_live();
    return mk(1'b1, 32'h1FFFF, 16);
  endfunction

  initial begin
    int unsigned sz, r;
    heap_clear();
    // directed
    pending_reqs.push_back(mk(0, 0, 0));          // zero size
    pending_reqs.push_back(mk(1, 0, 16));         // free of free chunk
    pending_reqs.push_back(mk(0, 65536, 0));      // huge
    pending_reqs.push_back(mk(0, 1, 0));          // rounds to 4
    pending_reqs.push_back(mk(0, 5, 0));
    pending_reqs.push_back(mk(0, 100, 0));
    pending_reqs.push_back(mk(1, 0, 17));         // unaligned
    pending_reqs.push_back(mk(1, 0, 40));         // inside a chunk
    pending_reqs.push_back(mk(1, 0, 65535));      // beyond store
    pending_reqs.push_back(mk(1, 0, 0));
    pending_reqs.push_back(mk(1, 0, 36));         // middle: no merge
    pending_reqs.push_back(mk(1, 0, 16));         // merge with next
    pending_reqs.push_back(mk(1, 0, 16));         // already free
    pending_reqs.push_back(mk(1, 0, 56));         // inside a chunk, not a head
    pending_reqs.push_back(mk(0, 65504, 0));      // too large, out of memory
    pending_reqs.push_back(mk(0, 4, 0));          // fits and splits the free chunk
    pending_reqs.push_back(mk(1, 0, 16));
    pending_reqs.push_back(mk(0, 65512, 0));      // too large, out of memory
    pending_reqs.push_back(mk(0, 8, 0));          // fits and splits the free chunk
    pending_reqs.push_back(mk(1, 0, 16));
    pending_reqs.push_back(mk(0, 131071, 0));     // all request bits high
    pending_reqs.push_back(mk(1, 0, 65520));
    // random: mostly allocs of small sizes and frees of live payloads
    for (int i = 0; i < 1300; i++) begin
      r = $urandom_range(0, 99);
      if (r < 48) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071)
           : ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4096)
           : $urandom_range(0, 300);
        pending_reqs.push_back(mk(0, sz, $urandom));
      end else if (r < 90) pending_reqs.push_back(free_live());
      else pending_reqs.push_back(mk(1, $urandom_range(0, 131070),
                                     ($urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 4095) * 16)));
    end
    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    wait (pending_reqs.size() < 150);
    quiet = 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
